// ----- src/dts_pkg.sv -----
// Shared types, key and field codes, and calendar helpers for the date and time setter.
`timescale 1ns / 1ps

package dts_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int FIELD_W  = 3;
    localparam int KIND_W   = 3;

    typedef logic [YEAR_W-1:0]   t_year;
    typedef logic [MONTH_W-1:0]  t_month;
    typedef logic [DAY_W-1:0]    t_day;
    typedef logic [HOUR_W-1:0]   t_hour;
    typedef logic [MINUTE_W-1:0] t_minute;
    typedef logic [FIELD_W-1:0]  t_field;
    typedef logic [KIND_W-1:0]   t_kind;

    // key codes
    localparam t_kind KIND_UP    = 3'd0;
    localparam t_kind KIND_DOWN  = 3'd1;
    localparam t_kind KIND_OK    = 3'd2;
    localparam t_kind KIND_BACK  = 3'd3;
    localparam t_kind KIND_OTHER = 3'd4;
    localparam t_kind KIND_LOAD  = 3'd5;

    // field codes
    localparam t_field FIELD_YEAR   = 3'd0;
    localparam t_field FIELD_MONTH  = 3'd1;
    localparam t_field FIELD_DAY    = 3'd2;
    localparam t_field FIELD_HOUR   = 3'd3;
    localparam t_field FIELD_MINUTE = 3'd4;
    localparam t_field FIELD_OK     = 3'd5;

    localparam t_year   YEAR_MIN   = 14'd2024;
    localparam t_year   YEAR_MAX   = 14'd2099;
    localparam t_month  MONTH_MIN  = 4'd1;
    localparam t_month  MONTH_MAX  = 4'd12;
    localparam t_month  MONTH_FEB  = 4'd2;
    localparam t_day    DAY_MIN    = 5'd1;
    localparam t_day    DAY_FEB_LEAP = 5'd29;
    localparam t_hour   HOUR_MAX   = 5'd23;
    localparam t_minute MINUTE_MAX = 6'd59;

    // reset values
    localparam t_year   YEAR_RESET   = 14'd2024;
    localparam t_month  MONTH_RESET  = 4'd1;
    localparam t_day    DAY_RESET    = 5'd1;
    localparam t_hour   HOUR_RESET   = 5'd0;
    localparam t_minute MINUTE_RESET = 6'd0;

    localparam t_day MONTH_DAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                         5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    // 25 * INV25 == 1 mod 2^14; y is a multiple of 25 iff y * INV25 (mod 2^14) <= DIV25_LIMIT
    localparam t_year INV25       = 14'd7209;
    localparam t_year DIV25_LIMIT = 14'd655;

    function automatic logic is_leap(t_year y);
        t_year prod;
        logic  div4;
        logic  div16;
        logic  div25;
        prod  = YEAR_W'(y * INV25);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod <= DIV25_LIMIT);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    // month 0 uses the table slot of month 4, months 13..15 those of 1..3
    function automatic t_day days_in_month(t_month m, logic leap);
        logic [3:0] idx;
        t_day       d;
        if (m == 4'd0) begin
            idx = 4'd3;
        end else if (m > MONTH_MAX) begin
            idx = m - 4'd13;
        end else begin
            idx = m - 4'd1;
        end
        d = MONTH_DAYS[idx];
        if (m == MONTH_FEB && leap) begin
            d = DAY_FEB_LEAP;
        end
        return d;
    endfunction

endpackage

// ----- src/dts_if.sv -----
// Valid/ready channel interfaces for key words in and setter result words out.
`timescale 1ns / 1ps

interface dts_in_if
    import dts_pkg::*;
;
    logic    valid;
    logic    ready;
    t_kind   kind;
    logic    is_press;
    t_year   load_year;
    t_month  load_month;
    t_day    load_day;
    t_hour   load_hour;
    t_minute load_minute;

    modport source (
        output valid, kind, is_press, load_year, load_month, load_day, load_hour, load_minute,
        input  ready
    );
    modport sink (
        input  valid, kind, is_press, load_year, load_month, load_day, load_hour, load_minute,
        output ready
    );
endinterface

interface dts_out_if
    import dts_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    handled;
    logic    commit;
    logic    leave;
    t_year   year_out;
    t_month  month_out;
    t_day    day_out;
    t_hour   hour_out;
    t_minute minute_out;
    t_field  field_out;

    modport source (
        output valid, handled, commit, leave, year_out, month_out, day_out, hour_out,
               minute_out, field_out,
        input  ready
    );
    modport sink (
        input  valid, handled, commit, leave, year_out, month_out, day_out, hour_out,
               minute_out, field_out,
        output ready
    );
endinterface

// ----- src/date_time_setter_by_keys_unit.sv -----
// Date and time setter: key words load, step, advance, commit or leave an edited date and time.
// The result word of an accepted key word is on the output register in the next cycle.
// Throughput: one word per cycle; the whole update is one combinational pass into the
// edit registers, and input ready stays high while the result register is empty or taken.
// Reset (i_rst_n low, synchronous): 2024-01-01 00:00, field 0 selected, no result pending.
`timescale 1ns / 1ps

module date_time_setter_by_keys_unit
    import dts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dts_in_if.sink     i_in,
    dts_out_if.source  o_out
);

    // Edit state. While a result word is pending these registers are its payload:
    // no new word is taken until it leaves, so they cannot move under it.
    t_year   r_year;
    t_month  r_month;
    t_day    r_day;
    t_hour   r_hour;
    t_minute r_minute;
    t_field  r_field;

    // result flags and valid
    logic    r_out_valid;
    logic    r_handled;
    logic    r_commit;
    logic    r_leave;

    t_year   n_year;
    t_month  n_month;
    t_day    n_day;
    t_hour   n_hour;
    t_minute n_minute;
    t_field  n_field;
    logic    n_handled;
    logic    n_commit;
    logic    n_leave;

    logic    in_fire;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    // Next edit state and flags for the word at the input.
    always_comb begin
        logic [YEAR_W:0] year_sum;
        logic            step_up;
        t_day            dim;

        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_field   = r_field;
        n_handled = 1'b0;
        n_commit  = 1'b0;
        n_leave   = 1'b0;
        step_up   = (i_in.kind == KIND_UP);
        year_sum  = '0;
        dim       = '0;

        if (i_in.kind == KIND_LOAD) begin
            // load is taken as is, no clamping, press flag ignored
            n_year   = i_in.load_year;
            n_month  = i_in.load_month;
            n_day    = i_in.load_day;
            n_hour   = i_in.load_hour;
            n_minute = i_in.load_minute;
            n_field  = FIELD_YEAR;
        end else if (i_in.is_press && i_in.kind <= KIND_BACK) begin
            n_handled = 1'b1;
            unique case (i_in.kind)
                KIND_UP, KIND_DOWN: begin
                    unique case (r_field)
                        FIELD_YEAR: begin
                            // saturate into the supported year window
                            if (step_up) begin
                                year_sum = {1'b0, r_year} + 1'b1;
                            end else if (r_year == '0) begin
                                year_sum = '0;
                            end else begin
                                year_sum = {1'b0, r_year} - 1'b1;
                            end
                            if (year_sum < {1'b0, YEAR_MIN}) begin
                                n_year = YEAR_MIN;
                            end else if (year_sum > {1'b0, YEAR_MAX}) begin
                                n_year = YEAR_MAX;
                            end else begin
                                n_year = year_sum[YEAR_W-1:0];
                            end
                        end
                        FIELD_MONTH: begin
                            // a step that lands above 12 wraps to 1
                            if (step_up) begin
                                n_month = (r_month >= MONTH_MAX) ? MONTH_MIN : r_month + 1'b1;
                            end else if (r_month <= MONTH_MIN) begin
                                n_month = MONTH_MAX;
                            end else if (r_month - 1'b1 > MONTH_MAX) begin
                                n_month = MONTH_MIN;
                            end else begin
                                n_month = r_month - 1'b1;
                            end
                        end
                        FIELD_DAY: begin
                            // wraps at the length of the current (maybe illegal) month
                            dim = days_in_month(r_month, is_leap(r_year));
                            if (step_up) begin
                                n_day = (r_day >= dim) ? DAY_MIN : r_day + 1'b1;
                            end else if (r_day <= DAY_MIN) begin
                                n_day = dim;
                            end else if (r_day - 1'b1 > dim) begin
                                n_day = DAY_MIN;
                            end else begin
                                n_day = r_day - 1'b1;
                            end
                        end
                        FIELD_HOUR: begin
                            if (step_up) begin
                                n_hour = (r_hour >= HOUR_MAX) ? '0 : r_hour + 1'b1;
                            end else if (r_hour == '0) begin
                                n_hour = HOUR_MAX;
                            end else if (r_hour - 1'b1 > HOUR_MAX) begin
                                n_hour = '0;
                            end else begin
                                n_hour = r_hour - 1'b1;
                            end
                        end
                        FIELD_MINUTE: begin
                            if (step_up) begin
                                n_minute = (r_minute >= MINUTE_MAX) ? '0 : r_minute + 1'b1;
                            end else if (r_minute == '0) begin
                                n_minute = MINUTE_MAX;
                            end else if (r_minute - 1'b1 > MINUTE_MAX) begin
                                n_minute = '0;
                            end else begin
                                n_minute = r_minute - 1'b1;
                            end
                        end
                        default: begin
                            // OK position selected: nothing to step, clamp only
                        end
                    endcase

                    // clamp after every step
                    if (n_month < MONTH_MIN) begin
                        n_month = MONTH_MIN;
                    end else if (n_month > MONTH_MAX) begin
                        n_month = MONTH_MAX;
                    end
                    if (n_day < DAY_MIN) begin
                        n_day = DAY_MIN;
                    end
                    dim = days_in_month(n_month, is_leap(n_year));
                    if (n_day > dim) begin
                        n_day = dim;
                    end
                    if (n_hour > HOUR_MAX) begin
                        n_hour = HOUR_MAX;
                    end
                    if (n_minute > MINUTE_MAX) begin
                        n_minute = MINUTE_MAX;
                    end
                end
                KIND_OK: begin
                    if (r_field == FIELD_OK) begin
                        n_commit = 1'b1;
                        n_leave  = 1'b1;
                    end else begin
                        n_field = r_field + 1'b1;
                    end
                end
                KIND_BACK: begin
                    n_leave = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year      <= YEAR_RESET;
            r_month     <= MONTH_RESET;
            r_day       <= DAY_RESET;
            r_hour      <= HOUR_RESET;
            r_minute    <= MINUTE_RESET;
            r_field     <= FIELD_YEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_year      <= n_year;
                r_month     <= n_month;
                r_day       <= n_day;
                r_hour      <= n_hour;
                r_minute    <= n_minute;
                r_field     <= n_field;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // flags are payload only
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_handled <= n_handled;
            r_commit  <= n_commit;
            r_leave   <= n_leave;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.handled    = r_handled;
    assign o_out.commit     = r_commit;
    assign o_out.leave      = r_leave;
    assign o_out.year_out   = r_year;
    assign o_out.month_out  = r_month;
    assign o_out.day_out    = r_day;
    assign o_out.hour_out   = r_hour;
    assign o_out.minute_out = r_minute;
    assign o_out.field_out  = r_field;

endmodule

// ----- src/dts_checker.sv -----
// Port-level checks for the date and time setter, bound to its top level.
`timescale 1ns / 1ps

module dts_checker
    import dts_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input t_kind   i_in_kind,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input logic    i_handled,
    input logic    i_commit,
    input logic    i_leave,
    input t_year   i_year_out,
    input t_field  i_field_out
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_year_out)
            && $stable(i_field_out) && $stable(i_commit))
        else $error("result word changed while stalled");

    // an empty output stage never holds off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output stage");

    // commit only from the OK position, and it always leaves
    a_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_commit |-> i_handled && i_leave && i_field_out == FIELD_OK)
        else $error("bad commit word");

    // a load word comes back next cycle, unhandled, with the year field selected
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == KIND_LOAD |=>
            i_out_valid && !i_handled && !i_leave && i_field_out == FIELD_YEAR)
        else $error("load word result wrong");

endmodule

bind date_time_setter_by_keys_unit dts_checker u_dts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_handled   (o_out.handled),
    .i_commit    (o_out.commit),
    .i_leave     (o_out.leave),
    .i_year_out  (o_out.year_out),
    .i_field_out (o_out.field_out)
);

// ----- test/date_time_setter_by_keys_unit_tb.sv -----
// Self-checking testbench for the date and time setter: directed key table, then random key words.
`timescale 1ns / 1ps

module date_time_setter_by_keys_unit_tb;
    import dts_pkg::*;

    // Clock and run control.
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    // The slowest correct run (idle gaps, output stalls, one long hold) stays well under
    // this limit for about 1750 words, so it leaves a wide margin.
    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 8;     // result register is loaded in the cycle after a word is taken
    localparam int IDLE_PCT      = 14;
    localparam int RANDOM_KEYS   = 1700;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AT       = 700;
    localparam int PAUSE_AT      = 1200;
    localparam int CALM_FROM     = 300;
    localparam int CALM_TO       = 550;

    // Key codes the package leaves unnamed; the block must ignore them.
    localparam t_kind KIND_SPARE6 = 3'd6;
    localparam t_kind KIND_SPARE7 = 3'd7;

    // Calendar bounds as plain ints, so that signed step arithmetic compares correctly.
    localparam int FIRST_YEAR  = 2024;
    localparam int LAST_YEAR   = 2099;
    localparam int LAST_MONTH  = 12;
    localparam int LAST_HOUR   = 23;
    localparam int LAST_MINUTE = 59;
    localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        t_kind   kind;
        logic    press;
        t_year   year;
        t_month  month;
        t_day    day;
        t_hour   hour;
        t_minute minute;
    } t_key;

    typedef struct packed {
        logic    handled;
        logic    commit;
        logic    leave;
        t_year   year;
        t_month  month;
        t_day    day;
        t_hour   hour;
        t_minute minute;
        t_field  field;
    } t_result;

    // One directed row: the key word, and a hand-typed result where it is obvious.
    typedef struct packed {
        t_key    key;
        bit      typed;
        t_result want;
    } t_row;

    localparam t_result NO_WANT   = '0;
    localparam int      PLAN_ROWS = 26;

    // Directed walk: reset values, year clamps at both ends, a load at the top of every
    // field, wrap of every other field both ways, a step on the OK field, commit, back, spare
    // kinds, an all-zero load, and a Feb 29 of non-leap 2100 cut to Feb 28 as the year clamps.
    localparam t_row PLAN [PLAN_ROWS] = '{
        '{'{KIND_OTHER, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b1,
          '{1'b0, 1'b0, 1'b0, YEAR_RESET, MONTH_RESET, DAY_RESET, HOUR_RESET,
            MINUTE_RESET, FIELD_YEAR}},
        '{'{KIND_DOWN, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b1,
          '{1'b1, 1'b0, 1'b0, YEAR_MIN, MONTH_RESET, DAY_RESET, HOUR_RESET,
            MINUTE_RESET, FIELD_YEAR}},
        '{'{KIND_UP, 1'b0, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_LOAD, 1'b0, 14'd9999, 4'd15, 5'd31, 5'd31, 6'd63}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 14'd9999, 4'd15, 5'd31, 5'd31, 6'd63, FIELD_YEAR}},
        '{'{KIND_UP, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b1,
          '{1'b1, 1'b0, 1'b0, YEAR_MAX, MONTH_MAX, 5'd31, HOUR_MAX, MINUTE_MAX,
            FIELD_YEAR}},
        '{'{KIND_OK,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_UP,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_DOWN, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_OK,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_UP,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_DOWN, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_OK,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_UP,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_DOWN, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_OK,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_UP,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_DOWN, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_OK,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_DOWN, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_OK, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b1,
          '{1'b1, 1'b1, 1'b1, YEAR_MAX, MONTH_MAX, 5'd31, HOUR_MAX, MINUTE_MAX,
            FIELD_OK}},
        '{'{KIND_BACK,   1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_SPARE6, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_SPARE7, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b0, NO_WANT},
        '{'{KIND_LOAD, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0, FIELD_YEAR}},
        '{'{KIND_LOAD, 1'b1, 14'd2100, 4'd2, 5'd29, 5'd12, 6'd30}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 14'd2100, 4'd2, 5'd29, 5'd12, 6'd30, FIELD_YEAR}},
        '{'{KIND_UP, 1'b1, 14'd0, 4'd0, 5'd0, 5'd0, 6'd0}, 1'b1,
          '{1'b1, 1'b0, 1'b0, YEAR_MAX, 4'd2, 5'd28, 5'd12, 6'd30, FIELD_YEAR}}
    };

    logic clk;
    logic rst_n;

    dts_in_if  in_ch ();
    dts_out_if out_ch ();

    date_time_setter_by_keys_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted edit state, kept apart from the block.
    t_year   ed_year;
    t_month  ed_month;
    t_day    ed_day;
    t_hour   ed_hour;
    t_minute ed_minute;
    t_field  ed_field;

    t_result due_readouts [$];

    int  errors        = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  handled_seen  = 0;
    int  commits_seen  = 0;
    int  exits_seen    = 0;
    int  loads_sent    = 0;
    int  cycles        = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    bit  hold_go;
    bit  calm;

    always begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Days in a month as the block sees them, illegal months included:
    // month 0 takes the slot of April, months 13..15 wrap onto Jan..Mar.
    function automatic int month_len(input int yr, input int mo);
        int  len;
        bit  leap;
        len  = MONTH_LEN[(mo == 0) ? 3 : (mo - 1) % 12];
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        if (mo == 2 && leap) begin
            len = 29;
        end
        return len;
    endfunction

    // Pull month, day, hour and minute back into their legal ranges after a step.
    function automatic void settle();
        int mo;
        int dy;
        int dim;
        mo = int'(ed_month);
        dy = int'(ed_day);
        if (mo < 1) begin
            mo = 1;
        end
        if (mo > LAST_MONTH) begin
            mo = LAST_MONTH;
        end
        if (dy < 1) begin
            dy = 1;
        end
        dim = month_len(int'(ed_year), mo);
        if (dy > dim) begin
            dy = dim;
        end
        ed_month = t_month'(mo);
        ed_day   = t_day'(dy);
        if (int'(ed_hour) > LAST_HOUR) begin
            ed_hour = t_hour'(LAST_HOUR);
        end
        if (int'(ed_minute) > LAST_MINUTE) begin
            ed_minute = t_minute'(LAST_MINUTE);
        end
    endfunction

    // Up/down on the selected field; year saturates, the rest wrap.
    function automatic void step_selected(input int delta);
        int v;
        int dim;
        case (ed_field)
            FIELD_YEAR: begin
                v = int'(ed_year) + delta;
                if (v < FIRST_YEAR) begin
                    v = FIRST_YEAR;
                end
                if (v > LAST_YEAR) begin
                    v = LAST_YEAR;
                end
                ed_year = t_year'(v);
            end
            FIELD_MONTH: begin
                v = int'(ed_month) + delta;
                if (v < 1) begin
                    v = LAST_MONTH;
                end
                if (v > LAST_MONTH) begin
                    v = 1;
                end
                ed_month = t_month'(v);
            end
            FIELD_DAY: begin
                // wrap point uses the month as stored, even an illegal one
                dim = month_len(int'(ed_year), int'(ed_month));
                v   = int'(ed_day) + delta;
                if (v < 1) begin
                    v = dim;
                end
                if (v > dim) begin
                    v = 1;
                end
                ed_day = t_day'(v);
            end
            FIELD_HOUR: begin
                v = int'(ed_hour) + delta;
                if (v < 0) begin
                    v = LAST_HOUR;
                end
                if (v > LAST_HOUR) begin
                    v = 0;
                end
                ed_hour = t_hour'(v);
            end
            FIELD_MINUTE: begin
                v = int'(ed_minute) + delta;
                if (v < 0) begin
                    v = LAST_MINUTE;
                end
                if (v > LAST_MINUTE) begin
                    v = 0;
                end
                ed_minute = t_minute'(v);
            end
            default: begin
            end
        endcase
        settle();
    endfunction

    // Advance the predicted state by one key word and return the result word it causes.
    function automatic t_result apply_key(input t_key k);
        t_result r;
        r = '0;
        if (k.kind == KIND_LOAD) begin
            // load takes the values raw, press or not
            ed_year   = k.year;
            ed_month  = k.month;
            ed_day    = k.day;
            ed_hour   = k.hour;
            ed_minute = k.minute;
            ed_field  = FIELD_YEAR;
        end else if (k.press && k.kind <= KIND_BACK) begin
            r.handled = 1'b1;
            case (k.kind)
                KIND_UP: begin
                    step_selected(1);
                end
                KIND_DOWN: begin
                    step_selected(-1);
                end
                KIND_OK: begin
                    if (ed_field == FIELD_OK) begin
                        r.commit = 1'b1;
                        r.leave  = 1'b1;
                    end else begin
                        ed_field = ed_field + 1'b1;
                    end
                end
                default: begin
                    r.leave = 1'b1;
                end
            endcase
        end
        r.year   = ed_year;
        r.month  = ed_month;
        r.day    = ed_day;
        r.hour   = ed_hour;
        r.minute = ed_minute;
        r.field  = ed_field;
        return r;
    endfunction

    // Offer one key word, with random idle cycles ahead of it, and record its result once taken.
    task automatic send_key(input t_key k, input bit typed, input t_result want);
        t_result r;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= k.kind;
        in_ch.is_press    <= k.press;
        in_ch.load_year   <= k.year;
        in_ch.load_month  <= k.month;
        in_ch.load_day    <= k.day;
        in_ch.load_hour   <= k.hour;
        in_ch.load_minute <= k.minute;
        do @(posedge clk); while (!in_ch.ready);
        r = apply_key(k);
        due_readouts.push_back(typed ? want : r);
        words_sent++;
        if (k.kind == KIND_LOAD) begin
            loads_sent++;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: check each taken word against the oldest prediction, and drive ready.
    // The long hold is counted here so that the sender keeps pushing meanwhile.
    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_readouts.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %h", $time,
                             {out_ch.handled, out_ch.commit, out_ch.leave, out_ch.year_out,
                              out_ch.month_out, out_ch.day_out, out_ch.hour_out,
                              out_ch.minute_out, out_ch.field_out});
                    errors++;
                end else begin
                    want = due_readouts.pop_front();
                    check_field("handled", want.handled, out_ch.handled);
                    check_field("commit",  want.commit,  out_ch.commit);
                    check_field("leave",   want.leave,   out_ch.leave);
                    check_field("year",    want.year,    out_ch.year_out);
                    check_field("month",   want.month,   out_ch.month_out);
                    check_field("day",     want.day,     out_ch.day_out);
                    check_field("hour",    want.hour,    out_ch.hour_out);
                    check_field("minute",  want.minute,  out_ch.minute_out);
                    check_field("field",   want.field,   out_ch.field_out);
                    results_seen++;
                    handled_seen += want.handled;
                    commits_seen += want.commit;
                    exits_seen   += want.leave;
                end
            end
            if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (hold_go && !hold_done) begin
                out_ch.ready <= 1'b0;
                hold_left    <= HOLD_CYCLES;
                hold_done    <= 1'b1;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_readouts.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_key k;
        int   pick;
        int   keys_done;
        bit   hold_asked;
        bit   paused;

        keys_done  = 0;
        hold_asked = 1'b0;
        paused     = 1'b0;

        rst_n             = 1'b0;
        calm              = 1'b0;
        hold_go           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_OTHER;
        in_ch.is_press    = 1'b0;
        in_ch.load_year   = '0;
        in_ch.load_month  = '0;
        in_ch.load_day    = '0;
        in_ch.load_hour   = '0;
        in_ch.load_minute = '0;

        ed_year   = YEAR_RESET;
        ed_month  = MONTH_RESET;
        ed_day    = DAY_RESET;
        ed_hour   = HOUR_RESET;
        ed_minute = MINUTE_RESET;
        ed_field  = FIELD_YEAR;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            send_key(PLAN[i].key, PLAN[i].typed, PLAN[i].want);
        end

        // Random part: mostly presses that walk the fields toward a commit, some loads (half
        // in bounds bar the day, half anywhere in range), and a sprinkling of ignored words.
        while (keys_done < RANDOM_KEYS) begin
            if (keys_done == CALM_FROM) begin
                calm <= 1'b1;
            end
            if (keys_done == CALM_TO) begin
                calm <= 1'b0;
            end
            if (keys_done == HOLD_AT && !hold_asked) begin
                hold_go    <= 1'b1;
                hold_asked = 1'b1;
            end
            if (keys_done == PAUSE_AT && !paused) begin
                // let the block run dry before the next word
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                while (due_readouts.size() != 0) @(posedge clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 32) begin
                k.kind = KIND_UP;
            end else if (pick < 58) begin
                k.kind = KIND_DOWN;
            end else if (pick < 83) begin
                k.kind = KIND_OK;
            end else if (pick < 87) begin
                k.kind = KIND_BACK;
            end else if (pick < 91) begin
                k.kind = KIND_OTHER;
            end else if (pick < 94) begin
                k.kind = pick[0] ? KIND_SPARE6 : KIND_SPARE7;
            end else begin
                k.kind = KIND_LOAD;
            end
            k.press = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 1) != 0) begin
                k.year   = t_year'($urandom_range(FIRST_YEAR, LAST_YEAR));
                k.month  = t_month'($urandom_range(1, LAST_MONTH));
                k.day    = t_day'($urandom_range(1, 31));
                k.hour   = t_hour'($urandom_range(0, LAST_HOUR));
                k.minute = t_minute'($urandom_range(0, LAST_MINUTE));
            end else begin
                k.year   = t_year'($urandom_range(0, 9999));
                k.month  = t_month'($urandom_range(0, 15));
                k.day    = t_day'($urandom_range(0, 31));
                k.hour   = t_hour'($urandom_range(0, 31));
                k.minute = t_minute'($urandom_range(0, 63));
            end

            send_key(k, 1'b0, NO_WANT);
            keys_done++;
        end

        in_ch.valid <= 1'b0;
        while (due_readouts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d key words sent (%0d loads), %0d results checked",
                 words_sent, loads_sent, results_seen);
        $display("summary: %0d handled, %0d commits, %0d exits, %0d-cycle output hold",
                 handled_seen, commits_seen, exits_seen, HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
